// File: hw/rtl/tmf_pkg.sv
// Package for the multichannel trimmed-mean filter: sizes, constants and
// the item and status types shared by the front end, the queue and the back end.
// Depends on nothing.
`timescale 1ns / 1ps

package tmf_pkg;

	// Number of analog channels held in the sample store.
	localparam int CHANNELS = 16;
	// Samples kept per channel (ring depth).
	localparam int TAPS = 5;
	// Depth of the queue between the front end and the back end.
	localparam int FIFO_DEPTH = 4;

	localparam int CH_W = 4;
	localparam int RAW_W = 16;
	localparam int SAMPLE_W = 16;
	localparam int CODE_W = 12;
	localparam int SLOT_W = 3;
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int FIFO_IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Sum of all taps, sum without min and max, and the divide-by-3 reciprocal.
	localparam int SUM_W = 19;
	localparam int TRIM_W = 18;
	localparam int RECIP_W = 18;
	localparam int RECIP_SH = 19;
	localparam int PROD_W = TRIM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_K = 18'd174763;

	// Converter word handling.
	localparam int OVF_BIT = 12;
	localparam logic [CODE_W-1:0] OVF_CODE = 12'h7ff;
	localparam logic [RAW_W-1:0] MID_OFFSET = 16'h0800;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TAPS - 1);

	typedef logic [TAPS-1:0][SAMPLE_W-1:0] tmf_row_t;

	// One classified item as it travels from the front end to the back end.
	typedef struct packed {
		logic [CH_W-1:0] channel;
		logic [SAMPLE_W-1:0] sample;
		logic [SLOT_W-1:0] slot;
		logic in_range;
		logic wr_en;
	} tmf_item_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} tmf_fifo_stat_t;

endpackage

// File: hw/rtl/tmf_front.sv
// Front end of the trimmed-mean filter: accepts converter results, converts
// the raw word to a 16-bit sample and tags it with the current ring slot.
// Depends on tmf_pkg.
`timescale 1ns / 1ps

module tmf_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [tmf_pkg::CH_W-1:0]     channel,
	input  logic [tmf_pkg::RAW_W-1:0]    raw_reading,
	input  logic                         timed_out,
	input  logic                         end_of_scan,
	input  tmf_pkg::tmf_fifo_stat_t      fifo_stat,
	output logic                         push,
	output tmf_pkg::tmf_item_t           item
);
	import tmf_pkg::*;

	logic [SLOT_W-1:0] slot_q;
	logic [RAW_W-1:0] centered;
	logic [CODE_W-1:0] code;
	logic in_range;

	// A transfer happens when the input is valid and the queue has room.
	assign push = in_valid && !fifo_stat.full;

	// Overflow saturates; otherwise remove the mid-scale offset and keep 12 bits.
	assign centered = raw_reading - MID_OFFSET;
	assign code = raw_reading[OVF_BIT] ? OVF_CODE : centered[CODE_W-1:0];
	assign in_range = ({1'b0, channel} < (CH_W + 1)'(CHANNELS));

	always_comb begin
		item.channel = channel;
		item.sample = {code, 4'h0};
		item.slot = slot_q;
		item.in_range = in_range;
		item.wr_en = in_range && !timed_out;
	end

	// Ring slot shared by all channels; it moves on after the end of a scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (push && end_of_scan) begin
			if (slot_q >= LAST_SLOT) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + SLOT_W'(1);
			end
		end
	end

endmodule

// File: hw/rtl/tmf_fifo.sv
// Short queue of classified items between the front end and the back end.
// Depends on tmf_pkg.
`timescale 1ns / 1ps

module tmf_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  tmf_pkg::tmf_item_t      push_item,
	input  logic                    pop,
	output tmf_pkg::tmf_item_t      head_item,
	output tmf_pkg::tmf_fifo_stat_t stat
);
	import tmf_pkg::*;

	tmf_item_t entries_q [FIFO_DEPTH];
	logic [FIFO_IDX_W-1:0] wr_ptr_q;
	logic [FIFO_IDX_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign stat.full = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head_item = entries_q[rd_ptr_q];

	// Entry storage; no reset needed for payload.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_IDX_W'(FIFO_DEPTH - 1)) ? '0
					: wr_ptr_q + FIFO_IDX_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_IDX_W'(FIFO_DEPTH - 1)) ? '0
					: rd_ptr_q + FIFO_IDX_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

endmodule

// File: hw/rtl/tmf_back.sv
// Back end of the trimmed-mean filter: read-modify-write of the per-channel
// sample row, then min, max and sum, trimming and divide by three.
// Depends on tmf_pkg.
`timescale 1ns / 1ps

module tmf_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tmf_pkg::tmf_item_t           head_item,
	input  tmf_pkg::tmf_fifo_stat_t      fifo_stat,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tmf_pkg::CH_W-1:0]     out_channel,
	output logic [tmf_pkg::SAMPLE_W-1:0] filtered_value,
	output logic                         sample_valid
);
	import tmf_pkg::*;

	// Sample store: one row of all taps per channel.
	tmf_row_t mem [CHANNELS];
	logic [CHANNELS-1:0] row_ok_q;

	logic adv;
	logic [CH_IDX_W-1:0] head_idx;
	logic [CH_IDX_W-1:0] idx_s2;

	logic v_s2, v_s3, v_s4, v_s5, out_valid_q;
	tmf_item_t item_s2, item_s3, item_s4, item_s5;
	tmf_row_t rd_s2;
	logic rd_ok_s2;
	tmf_row_t cur_row, new_row, row_s3;

	logic [SAMPLE_W-1:0] lo, hi;
	logic [SUM_W-1:0] sum;
	logic [SAMPLE_W-1:0] lo_s4, hi_s4;
	logic [SUM_W-1:0] sum_s4;
	logic [SUM_W-1:0] trim_full;
	logic [TRIM_W-1:0] trim_s5;
	logic [PROD_W-1:0] prod;

	logic [CH_W-1:0] out_channel_q;
	logic [SAMPLE_W-1:0] value_q;
	logic sample_valid_q;

	// The whole back pipeline moves together when the output can take an item.
	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !fifo_stat.empty;
	assign head_idx = head_item.channel[CH_IDX_W-1:0];
	assign idx_s2 = item_s2.channel[CH_IDX_W-1:0];

	// Row read; registered data lands together with the item in stage two.
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s2 <= mem[head_idx];
			rd_ok_s2 <= row_ok_q[head_idx];
		end
	end

	// The item one stage ahead wrote its row at the same edge as this read,
	// so take its row when it was for the same channel.
	always_comb begin
		if (v_s3 && item_s3.in_range && (item_s3.channel == item_s2.channel)) begin
			cur_row = row_s3;
		end else if (rd_ok_s2) begin
			cur_row = rd_s2;
		end else begin
			cur_row = '0;
		end
		new_row = cur_row;
		if (item_s2.wr_en) begin
			new_row[item_s2.slot] = item_s2.sample;
		end
	end

	// Row write-back.
	always_ff @(posedge clk) begin
		if (adv && v_s2 && item_s2.wr_en) begin
			mem[idx_s2] <= new_row;
		end
	end

	// Rows never written read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
		end else if (adv && v_s2 && item_s2.wr_en) begin
			row_ok_q[idx_s2] <= 1'b1;
		end
	end

	// Minimum, maximum and sum over the taps of one row.
	always_comb begin
		lo = row_s3[0];
		hi = row_s3[0];
		sum = SUM_W'(row_s3[0]);
		for (int i = 1; i < TAPS; i++) begin
			if (row_s3[i] < lo) begin
				lo = row_s3[i];
			end
			if (row_s3[i] > hi) begin
				hi = row_s3[i];
			end
			sum = sum + SUM_W'(row_s3[i]);
		end
	end

	// Drop min and max; divide by three with a reciprocal multiply.
	assign trim_full = sum_s4 - SUM_W'(lo_s4) - SUM_W'(hi_s4);
	assign prod = PROD_W'(trim_s5) * PROD_W'(RECIP_K);

	// Payload registers of the pipeline.
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2 <= head_item;
			item_s3 <= item_s2;
			row_s3 <= new_row;
			item_s4 <= item_s3;
			lo_s4 <= lo;
			hi_s4 <= hi;
			sum_s4 <= sum;
			item_s5 <= item_s4;
			trim_s5 <= trim_full[TRIM_W-1:0];
			out_channel_q <= item_s5.channel;
			value_q <= item_s5.in_range ? prod[RECIP_SH +: SAMPLE_W] : '0;
			sample_valid_q <= item_s5.wr_en;
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s2 <= pop;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	assign out_valid = out_valid_q;
	assign out_channel = out_channel_q;
	assign filtered_value = value_q;
	assign sample_valid = sample_valid_q;

endmodule

// File: hw/rtl/multichannel_trimmed_mean_filter_core.sv
// Top level of the multichannel trimmed-mean filter: front end, item queue
// and back end. Depends on tmf_pkg, tmf_front, tmf_fifo and tmf_back.
//
//   Port group   Direction  Handshake              Payload
//   input        in         in_valid / in_ready    channel, raw_reading, timed_out,
//                                                  end_of_scan
//   output       out        out_valid / out_ready  out_channel, filtered_value,
//                                                  sample_valid
//
// One item per cycle is sustained while the output is not stalled; an item
// passes the queue, row read, row update, min/max/sum, trim and divide by three.
// The per-channel row update is forwarded between adjacent items, so items for
// the same channel may follow each other in consecutive cycles.
// Reset clears the ring slot, the queue and the per-channel row flags; rows not
// yet written read as zero, so no clearing pass is needed.
// An output stall freezes the back end; the queue keeps accepting input until
// it holds four items.
`timescale 1ns / 1ps

module multichannel_trimmed_mean_filter_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tmf_pkg::CH_W-1:0]     channel,
	input  logic [tmf_pkg::RAW_W-1:0]    raw_reading,
	input  logic                         timed_out,
	input  logic                         end_of_scan,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tmf_pkg::CH_W-1:0]     out_channel,
	output logic [tmf_pkg::SAMPLE_W-1:0] filtered_value,
	output logic                         sample_valid
);
	import tmf_pkg::*;

	tmf_item_t push_item, head_item;
	tmf_fifo_stat_t fifo_stat;
	logic push, pop;

	assign in_ready = !fifo_stat.full;

	// Conversion and slot tagging.
	tmf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.channel     (channel),
		.raw_reading (raw_reading),
		.timed_out   (timed_out),
		.end_of_scan (end_of_scan),
		.fifo_stat   (fifo_stat),
		.push        (push),
		.item        (push_item)
	);

	// Queue between the two halves.
	tmf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.stat      (fifo_stat)
	);

	// Store update and filtering.
	tmf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_item      (head_item),
		.fifo_stat      (fifo_stat),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_channel    (out_channel),
		.filtered_value (filtered_value),
		.sample_valid   (sample_valid)
	);

`ifndef NO_ASSERTIONS
	// The back end never pops an empty queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_stat.empty)
		else $error("pop from empty queue");

	// The queue cannot be full and empty at once.
	a_stat_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_stat.full && fifo_stat.empty))
		else $error("queue status inconsistent");

	// A push is only taken when there is room.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> in_ready)
		else $error("push into full queue");

	// The trimmed mean of 16-bit samples with four low zero bits stays in range.
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (filtered_value <= 16'hfff0))
		else $error("filtered value out of range");
`endif

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the multichannel trimmed-mean filter core.
// Depends on tmf_pkg and multichannel_trimmed_mean_filter_core; results are
// checked against a filter model kept inside this file.
`timescale 1ns / 1ps

module tb_top;

	import tmf_pkg::*;

	localparam int RANDOM_ITEMS = 1600;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 24;
	localparam int DIRECTED_ROWS = 20;

	// One output transfer as the filter should produce it.
	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic [SAMPLE_W-1:0] value;
		logic valid;
	} mean_result_t;

	// One directed input row; the typed-in result is used when known is set.
	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic [RAW_W-1:0] raw;
		logic tmo;
		logic eos;
		logic known;
		logic [SAMPLE_W-1:0] exp_value;
		logic exp_valid;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CH_W-1:0] channel = '0;
	logic [RAW_W-1:0] raw_reading = '0;
	logic timed_out = 1'b0;
	logic end_of_scan = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CH_W-1:0] out_channel;
	logic [SAMPLE_W-1:0] filtered_value;
	logic sample_valid;

	// Model state: the per-channel sample ring and the shared slot pointer.
	logic [SAMPLE_W-1:0] tap_store [CHANNELS][TAPS];
	logic [SLOT_W-1:0] ring_slot;

	mean_result_t pending_means[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int quiet_cycles = 0;

	// Directed rows: extremes, overflow, timeout, end of scan and ring wrap.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{4'd0,  16'h0000, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b0},
		'{4'd0,  16'hffff, 1'b0, 1'b0, 1'b1, 16'h0000, 1'b1},
		'{4'd15, 16'h0800, 1'b0, 1'b0, 1'b1, 16'h0000, 1'b1},
		'{4'd15, 16'h07ff, 1'b0, 1'b1, 1'b1, 16'h0000, 1'b1},
		'{4'd15, 16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{4'd3,  16'h07ff, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{4'd3,  16'h07ff, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{4'd3,  16'h07ff, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{4'd3,  16'h07ff, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{4'd3,  16'h07ff, 1'b0, 1'b1, 1'b1, 16'hfff0, 1'b1},
		'{4'd3,  16'h1000, 1'b1, 1'b0, 1'b1, 16'hfff0, 1'b0},
		'{4'd3,  16'h1000, 1'b0, 1'b0, 1'b1, 16'hfff0, 1'b1},
		'{4'd3,  16'hefff, 1'b0, 1'b1, 1'b1, 16'hfff0, 1'b1},
		'{4'd7,  16'haaaa, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{4'd7,  16'h5555, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{4'd8,  16'h8000, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b0},
		'{4'd8,  16'h0fff, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{4'd3,  16'h0801, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{4'd15, 16'hf7ff, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{4'd0,  16'h1fff, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0}
	};

	multichannel_trimmed_mean_filter_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.channel(channel),
		.raw_reading(raw_reading),
		.timed_out(timed_out),
		.end_of_scan(end_of_scan),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_channel(out_channel),
		.filtered_value(filtered_value),
		.sample_valid(sample_valid)
	);

	always #5 clk = ~clk;

	// Updates the sample ring for one accepted item and returns the trimmed mean.
	function automatic mean_result_t filter_update(input logic [CH_W-1:0] ch,
			input logic [RAW_W-1:0] raw, input logic tmo, input logic eos);
		mean_result_t r;
		logic [RAW_W-1:0] code;
		int unsigned v, lo, hi, sum;
		int i;
		if (ring_slot >= TAPS)
			ring_slot = '0;
		r.ch = ch;
		r.value = '0;
		r.valid = 1'b0;
		if (ch < CHANNELS) begin
			if (!tmo) begin
				if (raw[OVF_BIT])
					code = {4'h0, OVF_CODE};
				else
					code = raw - MID_OFFSET;
				tap_store[ch][ring_slot] = {code[CODE_W-1:0], 4'h0};
				r.valid = 1'b1;
			end
			lo = 32'hffff;
			hi = 0;
			sum = 0;
			for (i = 0; i < TAPS; i++) begin
				v = 32'(tap_store[ch][i]);
				if (v < lo)
					lo = v;
				if (v > hi)
					hi = v;
				sum += v;
			end
			r.value = SAMPLE_W'((sum - lo - hi) / 3);
		end
		if (eos)
			ring_slot = (ring_slot == LAST_SLOT) ? '0 : ring_slot + 1'b1;
		return r;
	endfunction

	// Converter words weighted toward overflow, midscale and the extremes.
	function automatic logic [RAW_W-1:0] pick_raw();
		logic [RAW_W-1:0] w;
		w = RAW_W'($urandom);
		case ($urandom_range(5))
			0: w[OVF_BIT] = 1'b1;
			1: w = MID_OFFSET + RAW_W'($urandom_range(16)) - RAW_W'(8);
			2: w = $urandom_range(1) ? 16'h07ff : 16'h0800;
			3: w = $urandom_range(1) ? 16'hffff : 16'h0000;
			default: ;
		endcase
		return w;
	endfunction

	// Presents one item, holds it until the transfer, then records its result.
	task automatic send_item(input logic [CH_W-1:0] ch, input logic [RAW_W-1:0] raw,
			input logic tmo, input logic eos, input logic known,
			input logic [SAMPLE_W-1:0] exp_value, input logic exp_valid);
		mean_result_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		channel <= ch;
		raw_reading <= raw;
		timed_out <= tmo;
		end_of_scan <= eos;
		do
			@(posedge clk);
		while (!in_ready);
		r = filter_update(ch, raw, tmo, eos);
		if (known) begin
			r.value = exp_value;
			r.valid = exp_valid;
		end
		pending_means.push_back(r);
	endtask

	// Holds the input side idle until every outstanding result has come back.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_means.size() != 0)
			@(negedge clk);
	endtask

	// The receiver stalls at random according to the current idle rate.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Compare each output transfer with the oldest expected result.
	always @(posedge clk) begin
		mean_result_t e;
		if (out_valid && out_ready) begin
			if (pending_means.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: ch=%0d value=%h valid=%b",
						out_channel, filtered_value, sample_valid);
			end else begin
				e = pending_means.pop_front();
				if (out_channel !== e.ch || filtered_value !== e.value ||
						sample_valid !== e.valid) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected ch=%0d value=%h valid=%b, got ch=%0d value=%h valid=%b",
							e.ch, e.value, e.valid, out_channel, filtered_value,
							sample_valid);
				end
			end
		end
	end

	// Watchdog: give up when no transfer happens for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stimulus: directed rows, then random scans and noise in three idle phases.
	initial begin
		int k, n, first, sent, phase;
		int c, s;
		logic [CH_W-1:0] ch;
		for (c = 0; c < CHANNELS; c++)
			for (s = 0; s < TAPS; s++)
				tap_store[c][s] = '0;
		ring_slot = '0;
		send_idle_pct = 24;
		recv_idle_pct = 68;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < DIRECTED_ROWS; k++)
			send_item(directed_rows[k].ch, directed_rows[k].raw, directed_rows[k].tmo,
				directed_rows[k].eos, directed_rows[k].known,
				directed_rows[k].exp_value, directed_rows[k].exp_valid);
		drain_results();

		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			// Switch idle rates at each third, with the pipeline drained first.
			if (phase < 2 && sent >= (phase + 1) * RANDOM_ITEMS / 3) begin
				drain_results();
				phase++;
				send_idle_pct = (phase == 1) ? 68 : 0;
				recv_idle_pct = (phase == 1) ? 24 : 0;
			end
			if ($urandom_range(99) < 80) begin
				// A well-formed scan over consecutive channels, closed by end of scan.
				n = $urandom_range(1, CHANNELS);
				first = $urandom_range(CHANNELS - 1);
				for (k = 0; k < n; k++) begin
					ch = CH_W'(first + k);
					send_item(ch, pick_raw(), ($urandom_range(7) == 0), (k == n - 1),
						1'b0, '0, 1'b0);
				end
				sent += n;
			end else begin
				// Noise: any channel, any word, random flags.
				send_item(CH_W'($urandom), RAW_W'($urandom), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'b0, '0, 1'b0);
				sent++;
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
